// ===== rtl/psgf_pkg.sv =====
`timescale 1ns / 1ps
package psgf_pkg;

  localparam logic [31:0] HEAD_MAGIC    = 32'h1234_5678;
  localparam logic [31:0] VERSION_MAGIC = 32'hA1A1_A1A1;

  localparam logic [5:0]  MAX_FILL_RST  = 6'd63;
  localparam logic [31:0] MAX_GAP_RST   = 32'd1000000;

  localparam int ADDR_W  = 3;
  localparam int S_DATA_W = 264;   // 257 bits of fields, padded to bytes
  localparam int M_DATA_W = 192;

  typedef enum logic {
    REG_MAX_FILL = 1'b0,
    REG_MAX_GAP  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FILL,
    ST_REAL
  } state_t;

  typedef struct packed {
    logic [5:0]  max_fill;
    logic [31:0] max_gap;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic load_fill;
    logic load_real;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr_ok;
    logic resync;
    logic in_order;
    logic ahead;
    logic far_late;
    logic fill_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/psgf_cfg.sv =====
`timescale 1ns / 1ps
module psgf_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psgf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output psgf_pkg::cfg_t               cfg
);
  import psgf_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign idx   = reg_idx_t'(paddr[2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_fill <= MAX_FILL_RST;
      cfg.max_gap  <= MAX_GAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_FILL: cfg.max_fill <= pwdata[5:0];
        REG_MAX_GAP:  cfg.max_gap  <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_FILL: prdata = {26'd0, cfg.max_fill};
      REG_MAX_GAP:  prdata = cfg.max_gap;
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/psgf_ctrl.sv =====
`timescale 1ns / 1ps
module psgf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  psgf_pkg::dp_status_t  status,
  output psgf_pkg::dp_cmd_t     cmd
);
  import psgf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (!status.hdr_ok)                   state_next = ST_IDLE;
        else if (status.resync || status.in_order)     state_next = ST_REAL;
        else if (status.ahead)                         state_next = ST_FILL;
        else if (status.far_late)                      state_next = ST_REAL;
        else                                           state_next = ST_IDLE;
      end
      ST_FILL: begin
        if (status.fill_done) state_next = ST_REAL;
      end
      ST_REAL: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = (state == ST_IDLE);
    cmd.load_in   = (state == ST_IDLE) && s_tvalid;
    cmd.load_fill = (state == ST_FILL) && !status.fill_done && status.out_free;
    cmd.load_real = (state == ST_REAL) && status.out_free;
  end

endmodule

// ===== rtl/psgf_dp.sv =====
`timescale 1ns / 1ps
module psgf_dp #(
  parameter int FILL_LIMIT = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psgf_pkg::cfg_t                cfg,
  input  psgf_pkg::dp_cmd_t             cmd,
  output psgf_pkg::dp_status_t          status,
  input  logic [psgf_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [psgf_pkg::M_DATA_W-1:0] m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);
  import psgf_pkg::*;

  localparam int CNT_W = $clog2(FILL_LIMIT + 1);
  localparam logic [5:0] LIMIT6 = 6'(FILL_LIMIT);

  // captured header
  logic               in_len;
  logic [31:0]        in_head;
  logic [31:0]        in_ver;
  logic [63:0]        in_seq;
  logic signed [63:0] in_base;
  logic [63:0]        in_port;

  // block state
  logic [63:0]        expected_count;
  logic signed [63:0] held_base_ident;
  logic [63:0]        held_port_ident;
  logic               need_sync;

  // fill walk
  logic [63:0]        fill_seq;
  logic [CNT_W-1:0]   fill_cnt;
  logic [5:0]         limit6;
  logic [CNT_W-1:0]   limit;
  logic [63:0]        back_dist;

  assign limit6    = (cfg.max_fill < LIMIT6) ? cfg.max_fill : LIMIT6;
  assign limit     = CNT_W'(limit6);
  assign back_dist = expected_count - in_seq;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_len   <= s_tdata[0];
      in_head  <= s_tdata[32:1];
      in_ver   <= s_tdata[64:33];
      in_seq   <= s_tdata[128:65];
      in_base  <= s_tdata[192:129];
      in_port  <= s_tdata[256:193];
      fill_seq <= expected_count;
      fill_cnt <= '0;
    end else if (cmd.load_fill) begin
      fill_seq <= fill_seq + 64'd1;
      fill_cnt <= fill_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_count  <= '0;
      held_base_ident <= '0;
      held_port_ident <= '0;
      need_sync       <= 1'b1;
    end else if (cmd.load_real) begin
      expected_count  <= in_seq + 64'd1;
      held_base_ident <= in_base;
      held_port_ident <= in_port;
      need_sync       <= 1'b0;
    end
  end

  // one-deep output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_fill || cmd.load_real) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_real) begin
      m_tdata <= {in_port, in_base, in_seq};
      m_tuser <= 1'b0;
      m_tlast <= 1'b1;
    end else if (cmd.load_fill) begin
      m_tdata <= {held_port_ident, held_base_ident, fill_seq};
      m_tuser <= 1'b1;
      m_tlast <= 1'b0;
    end
  end

  always_comb begin
    status.hdr_ok    = in_len && (in_head == HEAD_MAGIC) && (in_ver == VERSION_MAGIC);
    status.resync    = need_sync || (in_seq == 64'd0);
    status.in_order  = (in_seq == expected_count);
    status.ahead     = (in_seq > expected_count);
    status.far_late  = (back_dist > {32'd0, cfg.max_gap});
    status.fill_done = (fill_cnt == limit) || (fill_seq == in_seq);
    status.out_free  = !m_tvalid || m_tready;
  end

endmodule

// ===== rtl/packet_sequence_gap_filler.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata: received header
// m_*       out  m_tvalid/m_tready   m_tdata: emitted header, m_tuser: fill, m_tlast
// APB       in   psel/penable        max_fill at 0x0, max_gap at 0x4
//
// Capture, check and load are the idle, eval and real states; a passed item
// goes through all three, a dropped one returns to idle after the check. Gaps
// get fill headers from the fill state. The controller sets this; s_tready
// is high in idle only. The output register is one deep, so a new item is taken
// while a result waits; a stalled receiver holds the next item in its load cycle.
// Reset (rst, synchronous) clears the stream state and needs no clearing pass.
module packet_sequence_gap_filler #(
  parameter int FILL_LIMIT = 63
) (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata, lowest bit up: length_ok[0], head_word[32:1], version_word[64:33],
  // seq_count[128:65], base_ident[192:129], port_ident[256:193], zero pad
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [psgf_pkg::S_DATA_W-1:0] s_tdata,
  // m_tdata, lowest bit up: out_seq_count[63:0], out_base_ident[127:64],
  // out_port_ident[191:128]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [psgf_pkg::M_DATA_W-1:0] m_tdata,
  // m_tuser: is_fill
  output logic                         m_tuser,
  output logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psgf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import psgf_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready = 1'b1;

  // register file
  psgf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer: capture, check, fill walk, real header
  psgf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // header capture, count compare, held ids and output register
  psgf_dp #(
    .FILL_LIMIT (FILL_LIMIT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
